// ===== hdl/bhe_pkg.sv =====
// Shared types, fixed-point constants and microcode for the hemodynamic step block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package bhe_pkg;

  // Transaction payloads.
  typedef struct packed {
    logic [9:0]         entry_index;
    logic signed [31:0] neural_activity;
  } in_t;

  typedef struct packed {
    logic signed [31:0] bold_signal;
    logic               domain_error;
  } out_t;

  // Queue entry between the front and the back.
  typedef struct packed {
    logic in_range;
    in_t  item;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qitem_t;

  localparam int FQ_DEPTH = 4;

  // Q8.24 constants.
  localparam logic signed [31:0] Q_MAX    = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN    = 32'sh80000000;
  localparam logic signed [31:0] C_ONE    = 32'sd16777216;
  localparam logic signed [31:0] C_INVTS  = 32'sd25811102;
  localparam logic signed [31:0] C_INVTF  = 32'sd40920039;
  localparam logic signed [31:0] C_INVTO  = 32'sd17119608;
  localparam logic signed [31:0] C_INVE0  = 32'sd41943040;
  localparam logic signed [31:0] C_RESID  = 32'sd10066330;
  localparam logic signed [31:0] C_GQ     = 32'sd186068721;
  localparam logic signed [31:0] C_GR     = 32'sd13421773;
  localparam logic signed [31:0] C_GV     = 32'sd33554432;
  localparam logic signed [31:0] C_K25    = 32'sd25;

  // State word after reset: signal zero, inflow, volume and content one.
  localparam logic [127:0] STATE_RESET = {32'd0, C_ONE, C_ONE, C_ONE};

  // Micro-operations of the back end.
  typedef enum logic [2:0] {
    OP_MUL  = 3'd0,
    OP_MUL3 = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_NEG  = 3'd4,
    OP_DIV  = 3'd5,
    OP_LOG  = 3'd6,
    OP_EXP  = 3'd7
  } op_t;

  // Operand identifiers: bit 4 clear selects the scratch memory.
  localparam logic [4:0] R_T0    = 5'd0;
  localparam logic [4:0] R_T1    = 5'd1;
  localparam logic [4:0] R_T2    = 5'd2;
  localparam logic [4:0] R_T3    = 5'd3;
  localparam logic [4:0] R_PV    = 5'd4;
  localparam logic [4:0] R_PO    = 5'd5;
  localparam logic [4:0] R_RAT   = 5'd6;
  localparam logic [4:0] R_DS    = 5'd7;
  localparam logic [4:0] R_DV    = 5'd8;
  localparam logic [4:0] R_DQ    = 5'd9;
  localparam logic [4:0] R_NSIG  = 5'd10;
  localparam logic [4:0] R_NFLO  = 5'd11;
  localparam logic [4:0] R_NVOL  = 5'd12;
  localparam logic [4:0] R_NDXY  = 5'd13;
  localparam logic [4:0] R_SIG   = 5'd16;
  localparam logic [4:0] R_FLO   = 5'd17;
  localparam logic [4:0] R_VOL   = 5'd18;
  localparam logic [4:0] R_DXY   = 5'd19;
  localparam logic [4:0] R_X     = 5'd20;
  localparam logic [4:0] R_DT    = 5'd21;
  localparam logic [4:0] R_ONE   = 5'd22;
  localparam logic [4:0] R_INVTS = 5'd23;
  localparam logic [4:0] R_INVTF = 5'd24;
  localparam logic [4:0] R_INVTO = 5'd25;
  localparam logic [4:0] R_INVE0 = 5'd26;
  localparam logic [4:0] R_RESID = 5'd27;
  localparam logic [4:0] R_GQ    = 5'd28;
  localparam logic [4:0] R_GR    = 5'd29;
  localparam logic [4:0] R_GV    = 5'd30;
  localparam logic [4:0] R_K25   = 5'd31;

  typedef struct packed {
    op_t        op;
    logic [4:0] dst;
    logic [4:0] a;
    logic [4:0] b;
  } uop_t;

  localparam int UCODE_LEN = 39;

  // One Euler step of the balloon model followed by the BOLD equation.
  localparam uop_t UCODE [UCODE_LEN] = '{
    '{OP_LOG,  R_T0,   R_VOL,   R_VOL},
    '{OP_MUL3, R_T0,   R_T0,    R_K25},
    '{OP_EXP,  R_PV,   R_T0,    R_T0},
    '{OP_LOG,  R_T1,   R_RESID, R_RESID},
    '{OP_NEG,  R_T1,   R_T1,    R_T1},
    '{OP_DIV,  R_T1,   R_T1,    R_FLO},
    '{OP_NEG,  R_T1,   R_T1,    R_T1},
    '{OP_EXP,  R_PO,   R_T1,    R_T1},
    '{OP_DIV,  R_RAT,  R_DXY,   R_VOL},
    '{OP_MUL,  R_T2,   R_INVTS, R_SIG},
    '{OP_SUB,  R_T2,   R_X,     R_T2},
    '{OP_SUB,  R_T3,   R_FLO,   R_ONE},
    '{OP_MUL,  R_T3,   R_INVTF, R_T3},
    '{OP_SUB,  R_DS,   R_T2,    R_T3},
    '{OP_SUB,  R_T2,   R_FLO,   R_PV},
    '{OP_MUL,  R_DV,   R_INVTO, R_T2},
    '{OP_SUB,  R_T2,   R_ONE,   R_PO},
    '{OP_MUL,  R_T2,   R_FLO,   R_T2},
    '{OP_MUL,  R_T2,   R_T2,    R_INVE0},
    '{OP_MUL,  R_T3,   R_PV,    R_RAT},
    '{OP_SUB,  R_T2,   R_T2,    R_T3},
    '{OP_MUL,  R_DQ,   R_INVTO, R_T2},
    '{OP_MUL,  R_T2,   R_DT,    R_DS},
    '{OP_ADD,  R_NSIG, R_SIG,   R_T2},
    '{OP_MUL,  R_T2,   R_DT,    R_SIG},
    '{OP_ADD,  R_NFLO, R_FLO,   R_T2},
    '{OP_MUL,  R_T2,   R_DT,    R_DV},
    '{OP_ADD,  R_NVOL, R_VOL,   R_T2},
    '{OP_MUL,  R_T2,   R_DT,    R_DQ},
    '{OP_ADD,  R_NDXY, R_DXY,   R_T2},
    '{OP_SUB,  R_T2,   R_ONE,   R_NDXY},
    '{OP_MUL,  R_T2,   R_GQ,    R_T2},
    '{OP_DIV,  R_T3,   R_NDXY,  R_NVOL},
    '{OP_SUB,  R_T3,   R_ONE,   R_T3},
    '{OP_MUL,  R_T3,   R_GR,    R_T3},
    '{OP_ADD,  R_T2,   R_T2,    R_T3},
    '{OP_SUB,  R_T3,   R_ONE,   R_NVOL},
    '{OP_MUL,  R_T3,   R_GV,    R_T3},
    '{OP_ADD,  R_T2,   R_T2,    R_T3}
  };

  // Saturate a wide signed value to the Q8.24 range.
  function automatic logic signed [31:0] sat_f(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) r = Q_MAX;
    else if (v < -42'sd2147483648) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // Integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt_f(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xx;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    xx = x;
    for (int i = 0; i < 32; i++) begin
      if (xx >= r + b) begin
        xx = xx - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Factors 2^(2^-k) in Q1.30 for k = 1..24.
  typedef logic [23:0][30:0] exp_tab_t;

  function automatic exp_tab_t exp_tab_f();
    exp_tab_t    t;
    logic [63:0] c;
    c = 64'd2 << 30;
    for (int k = 0; k < 24; k++) begin
      c    = isqrt_f(c << 30);
      t[k] = c[30:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_f();

endpackage

// ===== hdl/bhe_front.sv =====
// Front end: accepts transactions, checks the entry index and queues them.
// Depends on bhe_pkg.
`timescale 1ns / 1ps
module bhe_front #(
  parameter int ENTRIES = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bhe_pkg::in_t   push_data,
  input  logic           pop,
  output logic           full,
  output bhe_pkg::qitem_t head
);
  import bhe_pkg::*;

  localparam int PW = $clog2(FQ_DEPTH);

  qent_t         qmem [FQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          in_range;

  // Index classification against the configured table depth.
  assign in_range = {7'd0, push_data.entry_index} < 17'(ENTRIES);

  assign full       = (cnt_r == (PW+1)'(FQ_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.ent   = qmem[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr_r] <= '{in_range: in_range, item: push_data};
    end
  end

endmodule

// ===== hdl/bhe_div.sv =====
// Bit-serial signed Q8.24 divider, (a * 2^24) / b truncated toward zero, saturated.
// Depends on bhe_pkg.
`timescale 1ns / 1ps
module bhe_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] q
);
  import bhe_pkg::*;

  logic        run_r;
  logic [5:0]  cnt_r;
  logic [55:0] dq_r, dq_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dv_r;
  logic        neg_r;
  logic        done_r;
  logic signed [31:0] q_r;
  logic [31:0] mag_a, mag_b;
  logic [32:0] rem_sh;
  logic        qbit;

  assign mag_a = a[31] ? 32'd0 - a : a;
  assign mag_b = b[31] ? 32'd0 - b : b;

  // One restoring step per cycle.
  always_comb begin
    rem_sh  = {rem_r, dq_r[55]};
    qbit    = rem_sh >= {1'b0, dv_r};
    rem_nxt = qbit ? 32'(rem_sh - {1'b0, dv_r}) : rem_sh[31:0];
    dq_nxt  = {dq_r[54:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (b == '0) begin
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
        end
      end else if (run_r && cnt_r == 6'd55) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= a[31] ^ b[31];
      dv_r  <= mag_b;
      dq_r  <= {mag_a, 24'd0};
      rem_r <= '0;
      cnt_r <= '0;
      if (b == '0) begin
        q_r <= (a > 0) ? Q_MAX : ((a < 0) ? Q_MIN : 32'sd0);
      end
    end else if (run_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
      // Last step: apply the sign and saturate the quotient.
      if (cnt_r == 6'd55) begin
        if (!neg_r) begin
          q_r <= (dq_nxt > 56'd2147483647) ? Q_MAX : dq_nxt[31:0];
        end else begin
          q_r <= (dq_nxt > 56'd2147483648) ? Q_MIN : 32'(56'd0 - dq_nxt);
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== hdl/bhe_back.sv =====
// Back end: state table, microcoded datapath with shared multiplier, log2, exp2
// and divider, and the result register. Depends on bhe_pkg and bhe_div.
`timescale 1ns / 1ps
module bhe_back #(
  parameter int ENTRIES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [24:0]     dt,
  input  bhe_pkg::qitem_t head,
  output logic            pop,
  output logic            clearing,
  output logic            out_valid,
  output bhe_pkg::out_t   out_data
);
  import bhe_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [15:0] {
    S_CLEAR  = 16'h0001,
    S_IDLE   = 16'h0002,
    S_READ   = 16'h0004,
    S_LOAD   = 16'h0008,
    S_FETCH  = 16'h0010,
    S_EXEC   = 16'h0020,
    S_MULP   = 16'h0040,
    S_MULW   = 16'h0080,
    S_DIVW   = 16'h0100,
    S_LGNORM = 16'h0200,
    S_LGP    = 16'h0400,
    S_LGW    = 16'h0800,
    S_EXSTEP = 16'h1000,
    S_EXMP   = 16'h2000,
    S_EXMW   = 16'h4000,
    S_STORE  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic [127:0]       smem [ENTRIES];
  logic [31:0]        tmem [16];
  logic [127:0]       mem_rd_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [AW-1:0]      addr;
  in_t                item_r;
  logic [5:0]         pc_r;
  uop_t               op;
  logic signed [31:0] sig_r, flo_r, vol_r, dxy_r;
  logic signed [31:0] nsig_r, nflo_r, nvol_r, ndxy_r, bold_r;
  logic signed [31:0] tmp_a_r, tmp_b_r, opa, opb;
  logic signed [31:0] mul_a_r, mul_b_r;
  logic signed [63:0] prod_r, prod_rnd, prod_shr;
  logic [30:0]        m_r;
  logic [4:0]         lg_n_r;
  logic [4:0]         cnt_r;
  logic [23:0]        frac_r;
  logic [7:0]         ex_sh_r;
  logic [8:0]         sh9;
  logic [31:0]        m2;
  logic               lg_bit;
  logic [30:0]        lg_mn;
  logic signed [31:0] lg_res, exp_fin, mul_res, mul3_res;
  logic signed [32:0] sum, dif;
  logic               exp_big, last, domain;
  logic               wb_en;
  logic signed [31:0] wb_val;
  logic               div_start, div_done;
  logic signed [31:0] div_q;
  logic               emit;
  out_t               emit_data;
  logic               out_valid_r;
  out_t               out_r;

  assign addr     = AW'(item_r.entry_index);
  assign op       = UCODE[pc_r];
  assign last     = (pc_r == 6'(UCODE_LEN - 1));
  assign pop      = (state_r == S_IDLE) && head.valid;
  assign clearing = (state_r == S_CLEAR);
  assign domain   = (mem_rd_r[95:64] == '0) || mem_rd_r[95] ||
                    (mem_rd_r[63:32] == '0) || mem_rd_r[63];

  // Operand selection: scratch memory, loaded state, input activity, step size or constant.
  function automatic logic signed [31:0] opnd_f(input logic [4:0] id,
                                                input logic signed [31:0] tmp);
    logic signed [31:0] v;
    case (id)
      R_SIG:   v = sig_r;
      R_FLO:   v = flo_r;
      R_VOL:   v = vol_r;
      R_DXY:   v = dxy_r;
      R_X:     v = item_r.neural_activity;
      R_DT:    v = {7'd0, dt};
      R_ONE:   v = C_ONE;
      R_INVTS: v = C_INVTS;
      R_INVTF: v = C_INVTF;
      R_INVTO: v = C_INVTO;
      R_INVE0: v = C_INVE0;
      R_RESID: v = C_RESID;
      R_GQ:    v = C_GQ;
      R_GR:    v = C_GR;
      R_GV:    v = C_GV;
      R_K25:   v = C_K25;
      default: v = tmp;
    endcase
    return v;
  endfunction

  assign opa = opnd_f(op.a, tmp_a_r);
  assign opb = opnd_f(op.b, tmp_b_r);

  // Arithmetic results.
  always_comb begin
    prod_rnd = prod_r + 64'sd8388608;
    prod_shr = prod_rnd >>> 24;
    mul_res  = sat_f(prod_shr[41:0]);
    mul3_res = prod_r[34:3];
    sum      = {opa[31], opa} + {opb[31], opb};
    dif      = {opa[31], opa} - {opb[31], opb};
    m2       = prod_r[61:30];
    lg_bit   = m2[31];
    lg_mn    = lg_bit ? m2[31:1] : m2[30:0];
    lg_res   = {8'({3'd0, lg_n_r}) - 8'd24, frac_r[22:0], lg_bit};
    exp_big  = $signed(opa[31:24]) >= 8'sd7;
    sh9      = 9'd6 - {opa[31], opa[31:24]};
    exp_fin  = (ex_sh_r > 8'd62) ? 32'sd0 : 32'({1'b0, m_r} >> ex_sh_r);
  end

  // Write-back of one micro-operation.
  always_comb begin
    wb_en  = 1'b0;
    wb_val = '0;
    case (state_r)
      S_EXEC: begin
        case (op.op)
          OP_ADD: begin
            wb_en  = 1'b1;
            wb_val = sat_f({{9{sum[32]}}, sum});
          end
          OP_SUB: begin
            wb_en  = 1'b1;
            wb_val = sat_f({{9{dif[32]}}, dif});
          end
          OP_NEG: begin
            wb_en  = 1'b1;
            wb_val = 32'sd0 - opa;
          end
          OP_EXP: begin
            wb_en  = exp_big;
            wb_val = Q_MAX;
          end
          default: wb_en = 1'b0;
        endcase
      end
      S_MULW: begin
        wb_en  = 1'b1;
        wb_val = (op.op == OP_MUL3) ? mul3_res : mul_res;
      end
      S_DIVW: begin
        wb_en  = div_done;
        wb_val = div_q;
      end
      S_LGW: begin
        wb_en  = (cnt_r == 5'd23);
        wb_val = lg_res;
      end
      S_EXSTEP: begin
        wb_en  = (cnt_r == 5'd24);
        wb_val = exp_fin;
      end
      default: wb_en = 1'b0;
    endcase
  end

  assign div_start = (state_r == S_EXEC) && (op.op == OP_DIV);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (clr_cnt_r == AW'(ENTRIES - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (head.valid && head.ent.in_range) state_nxt = S_READ;
      S_READ:   state_nxt = S_LOAD;
      S_LOAD:   state_nxt = domain ? S_IDLE : S_FETCH;
      S_FETCH:  state_nxt = S_EXEC;
      S_EXEC: begin
        case (op.op)
          OP_MUL, OP_MUL3: state_nxt = S_MULP;
          OP_DIV:          state_nxt = S_DIVW;
          OP_LOG:          state_nxt = S_LGNORM;
          OP_EXP: begin
            if (!exp_big) state_nxt = S_EXSTEP;
            else state_nxt = last ? S_STORE : S_FETCH;
          end
          default:         state_nxt = last ? S_STORE : S_FETCH;
        endcase
      end
      S_MULP:   state_nxt = S_MULW;
      S_MULW:   state_nxt = last ? S_STORE : S_FETCH;
      S_DIVW:   if (div_done) state_nxt = last ? S_STORE : S_FETCH;
      S_LGNORM: if (m_r[30]) state_nxt = S_LGP;
      S_LGP:    state_nxt = S_LGW;
      S_LGW: begin
        if (cnt_r == 5'd23) state_nxt = last ? S_STORE : S_FETCH;
        else state_nxt = S_LGP;
      end
      S_EXSTEP: begin
        if (cnt_r == 5'd24) state_nxt = last ? S_STORE : S_FETCH;
        else if (frac_r[23]) state_nxt = S_EXMP;
      end
      S_EXMP:   state_nxt = S_EXMW;
      S_EXMW:   state_nxt = S_EXSTEP;
      S_STORE:  state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // Result transaction.
  always_comb begin
    emit      = 1'b0;
    emit_data = '{bold_signal: 32'sd0, domain_error: 1'b0};
    case (state_r)
      S_IDLE:  emit = head.valid && !head.ent.in_range;
      S_LOAD: begin
        emit                   = domain;
        emit_data.domain_error = 1'b1;
      end
      S_STORE: begin
        emit                  = 1'b1;
        emit_data.bold_signal = bold_r;
      end
      default: emit = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // State table: clearing pass, write-back, registered read.
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      smem[clr_cnt_r] <= STATE_RESET;
    end else if (state_r == S_STORE) begin
      smem[addr] <= {nsig_r, nflo_r, nvol_r, ndxy_r};
    end
    mem_rd_r <= smem[addr];
  end

  // Scratch memory with two registered read ports.
  always_ff @(posedge clk) begin
    if (wb_en) tmem[op.dst[3:0]] <= wb_val;
    tmp_a_r <= tmem[op.a[3:0]];
    tmp_b_r <= tmem[op.b[3:0]];
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod_r <= mul_a_r * mul_b_r;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    out_r <= emit_data;
    if (pop) item_r <= head.ent.item;
    if (state_r == S_LOAD) begin
      sig_r <= mem_rd_r[127:96];
      flo_r <= mem_rd_r[95:64];
      vol_r <= mem_rd_r[63:32];
      dxy_r <= mem_rd_r[31:0];
      pc_r  <= '0;
    end
    if (wb_en) begin
      pc_r <= pc_r + 1'b1;
      if (op.dst == R_NSIG) nsig_r <= wb_val;
      if (op.dst == R_NFLO) nflo_r <= wb_val;
      if (op.dst == R_NVOL) nvol_r <= wb_val;
      if (op.dst == R_NDXY) ndxy_r <= wb_val;
      if (last) bold_r <= wb_val;
    end
    case (state_r)
      S_EXEC: begin
        mul_a_r <= opa;
        mul_b_r <= opb;
        cnt_r   <= '0;
        if (op.op == OP_LOG) begin
          m_r    <= opa[30:0];
          lg_n_r <= 5'd30;
          frac_r <= '0;
        end else begin
          m_r     <= 31'h4000_0000;
          frac_r  <= opa[23:0];
          ex_sh_r <= sh9[7:0];
        end
      end
      // Normalize the mantissa to Q1.30, one bit a cycle.
      S_LGNORM: begin
        if (!m_r[30]) begin
          m_r    <= {m_r[29:0], 1'b0};
          lg_n_r <= lg_n_r - 1'b1;
        end else begin
          mul_a_r <= {1'b0, m_r};
          mul_b_r <= {1'b0, m_r};
        end
      end
      // One squaring yields one fraction bit.
      S_LGW: begin
        m_r     <= lg_mn;
        frac_r  <= {frac_r[22:0], lg_bit};
        cnt_r   <= cnt_r + 1'b1;
        mul_a_r <= {1'b0, lg_mn};
        mul_b_r <= {1'b0, lg_mn};
      end
      // Walk the exponent fraction, multiplying in a factor for each set bit.
      S_EXSTEP: begin
        if (cnt_r != 5'd24) begin
          if (frac_r[23]) begin
            mul_a_r <= {1'b0, m_r};
            mul_b_r <= {1'b0, EXP_TAB[cnt_r]};
          end else begin
            cnt_r  <= cnt_r + 1'b1;
            frac_r <= {frac_r[22:0], 1'b0};
          end
        end
      end
      S_EXMW: begin
        m_r    <= prod_r[60:30];
        cnt_r  <= cnt_r + 1'b1;
        frac_r <= {frac_r[22:0], 1'b0};
      end
      default: ;
    endcase
  end

  bhe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (opa),
    .b     (opb),
    .done  (div_done),
    .q     (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/balloon_hemodynamic_euler_step.sv =====
// Top level of the balloon hemodynamic Euler step block: front queue, back
// datapath and the step size register. Depends on bhe_pkg, bhe_front, bhe_back.
`timescale 1ns / 1ps
// Each transaction advances one entry of the hemodynamic state table by one
// Euler step and returns one result a single cycle wide on out_valid; the
// receiver cannot hold results off, and results leave in arrival order. The
// front queue holds four transactions, so start is taken back to back while
// the back end works, until the queue is full. The back end runs one entry at
// a time through a microcoded datapath with one shared 32x32 multiplier, a
// bit-serial divider and serial log2 and exp2 units; the time an in-range
// entry takes is set mostly by the three divisions and by how many exponent
// fraction bits are set. An entry with a domain error leaves after the table
// read, and an index beyond the table leaves straight from the queue head.
// After reset the state table is cleared one entry a cycle, with busy high;
// step size writes are taken throughout.
module balloon_hemodynamic_euler_step #(
  parameter int ENTRIES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bhe_pkg::in_t  in_data,
  output logic          out_valid,
  output bhe_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [24:0]   cfg_wdata
);
  import bhe_pkg::*;

  logic        full, clearing, pop, push;
  qitem_t      head;
  logic [24:0] step_size_r;

  assign busy = full || clearing;
  assign push = start && !busy;

  // Step size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= 25'd16777;
    end else if (cfg_we) begin
      step_size_r <= cfg_wdata;
    end
  end

  bhe_front #(.ENTRIES(ENTRIES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_data),
    .pop       (pop),
    .full      (full),
    .head      (head)
  );

  bhe_back #(.ENTRIES(ENTRIES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dt        (step_size_r),
    .head      (head),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
